// ===== hdl/ggvs_pkg.sv =====
// Shared types and constants for the greedy garbage-collection victim selector.
`default_nettype none

package ggvs_pkg;

   // Fixed field widths of the request and response items.
   localparam int BLOCK_W = 10;
   localparam int COUNT_W = 7;
   localparam int SLOT_W  = 4;

   // Request operation codes. The remaining code is ignored.
   localparam logic [1:0] MODE_WRITE_BLOCK = 2'd0;
   localparam logic [1:0] MODE_WRITE_SLOT  = 2'd1;
   localparam logic [1:0] MODE_SELECT      = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [BLOCK_W-1:0] block_index;
      logic [COUNT_W-1:0] valid_count;
      logic               is_data;
      logic               page_mapped;
      logic               has_replacement;
      logic [SLOT_W-1:0]  slot;
      logic               slot_valid;
   } req_type;

   typedef struct packed {
      logic               victim_found;
      logic [BLOCK_W-1:0] victim_block;
      logic [COUNT_W-1:0] victim_valid;
   } rsp_type;

   // One entry of the per-block table memory.
   typedef struct packed {
      logic               has_replacement;
      logic               page_mapped;
      logic               is_data;
      logic [COUNT_W-1:0] valid_count;
   } block_entry_type;

   // Write port of the exclusion table.
   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  slot;
      logic [BLOCK_W-1:0] block;
      logic               in_use;
   } excl_wr_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/greedy_gc_victim_selector_top.sv =====
// Top level of the greedy garbage-collection victim selector.
`default_nettype none

// After reset the block runs a clearing pass over its per-block table
// memory and holds req_ready low until it ends. A select request reads the
// table through the single read port of its memory, one entry per cycle in
// ascending block order, and ends early when an eligible block with no valid
// pages is found. Only one request is worked on at a time, but a new request
// is taken while a finished response still waits in the output register.
module greedy_gc_victim_selector_top #(
   parameter int NUM_BLOCKS      = 1024,
   parameter int PAGES_PER_BLOCK = 64,
   parameter int EXCLUDE_SLOTS   = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  ggvs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output ggvs_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

   ggvs_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;
   logic             issue_ff, issue_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             found_ff, found_in;
   logic [ggvs_pkg::COUNT_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] victim_ff, victim_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ggvs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   ggvs_pkg::block_entry_type mem [NUM_BLOCKS];
   ggvs_pkg::block_entry_type rd_data_ff;

   logic accept;
   logic select_req;
   logic rsp_free;
   logic clr_run;
   logic scan_run;
   logic load_rsp;
   logic mem_we;
   logic [IDX_W-1:0] mem_waddr;
   ggvs_pkg::block_entry_type mem_wdata;
   logic excl_hit;
   logic eligible;
   logic below;
   logic win;
   logic scan_done;
   ggvs_pkg::excl_wr_type excl_wr;

   assign accept     = req_valid && req_ready;
   assign select_req = accept && (req_data.mode == ggvs_pkg::MODE_SELECT);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Exclusion table, looked up with the block whose entry is being checked.
   always_comb begin
      excl_wr.en     = accept && (req_data.mode == ggvs_pkg::MODE_WRITE_SLOT);
      excl_wr.slot   = req_data.slot;
      excl_wr.block  = req_data.block_index;
      excl_wr.in_use = req_data.slot_valid;
   end

   ggvs_excl_table #(
      .NUM_BLOCKS    (NUM_BLOCKS),
      .EXCLUDE_SLOTS (EXCLUDE_SLOTS)
   ) u_excl_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (excl_wr),
      .query_idx (chk_idx_ff),
      .hit       (excl_hit)
   );

   // Eligibility and comparison of the entry read in the previous cycle.
   always_comb begin
      eligible = rd_data_ff.is_data
                 && (rd_data_ff.page_mapped || rd_data_ff.has_replacement)
                 && !excl_hit;
      if (found_ff) begin
         below = rd_data_ff.valid_count < best_ff;
      end else begin
         below = 32'(rd_data_ff.valid_count) < PAGES_PER_BLOCK;
      end
      win       = chk_vld_ff && eligible && below;
      scan_done = chk_vld_ff
                  && ((win && (rd_data_ff.valid_count == '0)) || (chk_idx_ff == LAST_IDX));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ggvs_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_IDX) begin
               state_in = ggvs_pkg::ST_IDLE;
            end
         end
         ggvs_pkg::ST_IDLE: begin
            if (select_req) begin
               state_in = ggvs_pkg::ST_SCAN;
            end
         end
         ggvs_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = ggvs_pkg::ST_DONE;
            end
         end
         ggvs_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = ggvs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ggvs_pkg::ST_CLEAR;
         end
      endcase
   end

   // State-decoded controls.
   always_comb begin
      req_ready = 1'b0;
      clr_run   = 1'b0;
      scan_run  = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ggvs_pkg::ST_CLEAR: begin
            clr_run = 1'b1;
         end
         ggvs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ggvs_pkg::ST_SCAN: begin
            scan_run = 1'b1;
         end
         ggvs_pkg::ST_DONE: begin
            load_rsp = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Memory write port: clearing pass, or a block entry write in range.
   always_comb begin
      if (clr_run) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = accept && (req_data.mode == ggvs_pkg::MODE_WRITE_BLOCK)
                     && (32'(req_data.block_index) < NUM_BLOCKS);
         mem_waddr = IDX_W'(req_data.block_index);
         mem_wdata.has_replacement = req_data.has_replacement;
         mem_wdata.page_mapped     = req_data.page_mapped;
         mem_wdata.is_data         = req_data.is_data;
         mem_wdata.valid_count     = req_data.valid_count;
      end
   end

   // Scan datapath: one read issued per cycle, checked in the next cycle.
   always_comb begin
      clr_addr_in = clr_run ? clr_addr_ff + 1'b1 : clr_addr_ff;
      rd_addr_in  = rd_addr_ff;
      issue_in    = 1'b0;
      chk_vld_in  = 1'b0;
      chk_idx_in  = rd_addr_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      victim_in   = victim_ff;
      if (select_req) begin
         rd_addr_in = '0;
         issue_in   = 1'b1;
         found_in   = 1'b0;
         best_in    = '0;
         victim_in  = '0;
      end else if (scan_run) begin
         if (issue_ff) begin
            rd_addr_in = rd_addr_ff + 1'b1;
         end
         issue_in   = issue_ff && (rd_addr_ff != LAST_IDX) && !scan_done;
         chk_vld_in = issue_ff && !scan_done;
         if (win) begin
            found_in  = 1'b1;
            best_in   = rd_data_ff.valid_count;
            victim_in = chk_idx_ff;
         end
      end
   end

   // Response register; best and victim stay zero when nothing was found.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.victim_found  = found_ff;
         rsp_data_in.victim_block  = ggvs_pkg::BLOCK_W'(victim_ff);
         rsp_data_in.victim_valid  = best_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Per-block table memory with a registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (scan_run && issue_ff) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ggvs_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         issue_ff     <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      chk_idx_ff  <= chk_idx_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      victim_ff   <= victim_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== hdl/ggvs_excl_table.sv =====
// Exclusion table of blocks open for writes, with a parallel lookup of one block.
`default_nettype none

module ggvs_excl_table #(
   parameter int NUM_BLOCKS    = 1024,
   parameter int EXCLUDE_SLOTS = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   input  ggvs_pkg::excl_wr_type         wr,
   input  wire [$clog2(NUM_BLOCKS)-1:0]  query_idx,
   output logic                          hit
);

   logic [ggvs_pkg::BLOCK_W-1:0] block_ff  [EXCLUDE_SLOTS];
   logic [ggvs_pkg::BLOCK_W-1:0] block_in  [EXCLUDE_SLOTS];
   logic [EXCLUDE_SLOTS-1:0]     in_use_ff;
   logic [EXCLUDE_SLOTS-1:0]     in_use_in;

   // A write to a slot beyond the table matches no entry and is dropped.
   always_comb begin
      for (int s = 0; s < EXCLUDE_SLOTS; s++) begin
         block_in[s]  = block_ff[s];
         in_use_in[s] = in_use_ff[s];
         if (wr.en && (32'(wr.slot) == s)) begin
            block_in[s]  = wr.block;
            in_use_in[s] = wr.in_use;
         end
      end
   end

   // Slot contents need no reset; the in-use bits do.
   always_ff @(posedge clock) begin
      for (int s = 0; s < EXCLUDE_SLOTS; s++) begin
         block_ff[s] <= block_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   // A free slot excludes nothing, whatever block number it holds.
   always_comb begin
      hit = 1'b0;
      for (int s = 0; s < EXCLUDE_SLOTS; s++) begin
         if (in_use_ff[s] && (32'(block_ff[s]) == 32'(query_idx))) begin
            hit = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire
